@@ hw/rtl/calibration_bin_lookup_core_assert.svh @@
// Assertion macros for the calibration bin lookup block.
// Used by the checker bound to calibration_bin_lookup_core; no other dependencies.
`ifndef CALIBRATION_BIN_LOOKUP_CORE_ASSERT_SVH
`define CALIBRATION_BIN_LOOKUP_CORE_ASSERT_SVH

// Concurrent assertion, disabled while reset is asserted.
`define CBL_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define CBL_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cbl_pkg.sv @@
// Shared types and constants for the calibration bin lookup block.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package cbl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_W           = 32;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = 9;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 2'd0,
    REG_SEARCH_MODE = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic {
    MODE_UPPER = 1'b0,
    MODE_LOWER = 1'b1
  } mode_t;

endpackage

`default_nettype wire

@@ hw/rtl/cbl_channels.sv @@
// Valid/ready channel interfaces of the calibration bin lookup block.
// Depends on cbl_pkg for field widths.
`default_nettype none

interface cbl_in_if import cbl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0] entry_key;
  logic signed [KEY_W-1:0] entry_value;
  logic signed [KEY_W-1:0] score;

  modport source (output valid, action, entry_index, entry_key, entry_value, score,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_key, entry_value, score,
                  output ready);
endinterface

interface cbl_out_if import cbl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] calibrated;
  logic [IDX_W-1:0]        found_index;
  logic                    past_end;

  modport source (output valid, calibrated, found_index, past_end, input ready);
  modport sink   (input valid, calibrated, found_index, past_end, output ready);
endinterface

interface cbl_cfg_if import cbl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/calibration_bin_lookup_core.sv @@
// Calibration bin lookup: (key, value) table with a binary search over the keys.
// Depends on cbl_pkg and the channel interfaces in cbl_channels.sv.
//
// Usage:
//   in_bus  : one transaction per item. action=write stores (entry_key, entry_value)
//             at entry_index (slots at or above TABLE_DEPTH are dropped); action=lookup
//             searches the first entry_count keys for score.
//   out_bus : one transaction per lookup with the selected value, its slot and past_end.
//   cfg_bus : register writes, always ready; idx 0 entry_count, idx 1 search_mode.
// Sequencing:
//   A write is taken in ST_IDLE and does not leave it, so in_bus stays ready.
//   A lookup runs S probe steps, where S is at most ceil(log2(n+1)) (9 for a full
//   256-entry table): each probe reads the key RAM in ST_SEARCH, then does the signed
//   compare and bound update in ST_CMP; ST_DONE then registers the result for out_bus.
//   in_bus is not ready during the search.
// Reset: entry_count becomes 1, search_mode upper bound, out_bus goes idle.
//   The table RAMs are not cleared; slots read before being written are undefined.
// Stall: a result waits in the output register while out_bus.ready is low; the
//   next item is accepted meanwhile, and a finished search holds until the
//   output register is free.
`default_nettype none

module calibration_bin_lookup_core
  import cbl_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cbl_in_if.sink    in_bus,
  cbl_out_if.source out_bus,
  cbl_cfg_if.sink   cfg_bus
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (LW > CNT_W) ? LW : CNT_W;
  localparam int WW = (LW > IDX_W) ? LW : IDX_W;

  logic signed [KEY_W-1:0] keys_mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] vals_mem [TABLE_DEPTH];

  logic [CNT_W-1:0] entry_count_r;
  mode_t            search_mode_r;

  state_t                  state_r, state_nxt;
  logic [LW-1:0]           first_r, first_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [LW-1:0]           mid_r, mid_nxt;
  logic signed [KEY_W-1:0] score_r, score_nxt;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] val_q;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_calibrated_r, out_calibrated_nxt;
  logic [IDX_W-1:0]        out_found_index_r, out_found_index_nxt;
  logic                    out_past_end_r, out_past_end_nxt;

  logic [EW-1:0] cnt_ext;
  logic [LW-1:0] n_eff;
  logic [LW-1:0] half_c;
  logic [LW-1:0] mid_c;
  logic [LW-1:0] slot_c;
  logic          past_c;
  logic          go_right;
  logic          in_fire;
  logic [WW-1:0] wr_idx;
  logic          wr_en;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CNT_W'(1);
      search_mode_r <= MODE_UPPER;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      if (cfg_bus.idx == REG_ENTRY_COUNT) begin
        entry_count_r <= cfg_bus.data[CNT_W-1:0];
      end else if (cfg_bus.idx == REG_SEARCH_MODE) begin
        search_mode_r <= mode_t'(cfg_bus.data[0]);
      end
    end
  end

  // effective count, clamped to 1..TABLE_DEPTH
  always_comb begin
    cnt_ext = EW'(entry_count_r);
    if (cnt_ext == '0) begin
      n_eff = LW'(1);
    end else if (cnt_ext > EW'(TABLE_DEPTH)) begin
      n_eff = LW'(TABLE_DEPTH);
    end else begin
      n_eff = cnt_ext[LW-1:0];
    end
  end

  assign half_c = len_r >> 1;
  assign mid_c  = first_r + half_c;

  always_comb begin
    if ((search_mode_r == MODE_LOWER) && (first_r == n_eff)) begin
      slot_c = n_eff - LW'(1);
      past_c = 1'b1;
    end else begin
      slot_c = first_r;
      past_c = 1'b0;
    end
  end

  assign go_right = (search_mode_r == MODE_LOWER) ? (key_q < score_r) : (key_q <= score_r);

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign wr_idx       = WW'(in_bus.entry_index);
  assign wr_en        = in_fire && (in_bus.action == ACT_WRITE) &&
                        (wr_idx < WW'(TABLE_DEPTH));

  // table RAMs: one write port, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[wr_idx[AW-1:0]] <= in_bus.entry_key;
      vals_mem[wr_idx[AW-1:0]] <= in_bus.entry_value;
    end
    key_q <= keys_mem[mid_c[AW-1:0]];
    val_q <= vals_mem[slot_c[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r           <= first_nxt;
    len_r             <= len_nxt;
    mid_r             <= mid_nxt;
    score_r           <= score_nxt;
    out_calibrated_r  <= out_calibrated_nxt;
    out_found_index_r <= out_found_index_nxt;
    out_past_end_r    <= out_past_end_nxt;
  end

  always_comb begin
    state_nxt           = state_r;
    first_nxt           = first_r;
    len_nxt             = len_r;
    mid_nxt             = mid_r;
    score_nxt           = score_r;
    out_valid_nxt       = out_valid_r;
    out_calibrated_nxt  = out_calibrated_r;
    out_found_index_nxt = out_found_index_r;
    out_past_end_nxt    = out_past_end_r;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_bus.action == ACT_LOOKUP)) begin
          score_nxt = in_bus.score;
          first_nxt = '0;
          len_nxt   = (search_mode_r == MODE_LOWER) ? n_eff : (n_eff - LW'(1));
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (len_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          mid_nxt   = mid_c;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (go_right) begin
          first_nxt = mid_r + LW'(1);
          len_nxt   = len_r - half_c - LW'(1);
        end else begin
          len_nxt = half_c;
        end
        state_nxt = ST_SEARCH;
      end
      ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt       = 1'b1;
          out_calibrated_nxt  = val_q;
          out_found_index_nxt = IDX_W'(slot_c);
          out_past_end_nxt    = past_c;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.calibrated  = out_calibrated_r;
  assign out_bus.found_index = out_found_index_r;
  assign out_bus.past_end    = out_past_end_r;

endmodule

`default_nettype wire

@@ hw/rtl/cbl_checker.sv @@
// Port-level checker for calibration_bin_lookup_core, attached by bind.
// Depends on cbl_pkg and calibration_bin_lookup_core_assert.svh.
`default_nettype none

`include "calibration_bin_lookup_core_assert.svh"

module cbl_checker
  import cbl_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_action,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] out_calibrated,
  input logic [IDX_W-1:0]        out_found_index
);

  `CBL_ASSERT(a_idle_after_reset, clk, $past(!rst_n) |-> !out_valid, "out valid right after reset")

  `CBL_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_calibrated) && $stable(out_found_index), "stalled result changed")

  `CBL_ASSERT_RST(a_lookup_busy, clk, rst_n, in_valid && in_ready && (in_action == ACT_LOOKUP) |=> !in_ready, "input ready during search")

  `CBL_ASSERT_RST(a_write_silent, clk, rst_n, in_valid && in_ready && (in_action == ACT_WRITE) && !out_valid |=> !out_valid, "write transaction produced a result")

endmodule

bind calibration_bin_lookup_core cbl_checker u_cbl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_action       (in_bus.action),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_calibrated  (out_bus.calibrated),
  .out_found_index (out_bus.found_index)
);

`default_nettype wire

@@ dv/tb_calibration_bin_lookup_core.sv @@
// Testbench for calibration_bin_lookup_core: a directed table, then random phases over
// several entry counts, search modes and handshake idling, scored against a local predictor.
// Depends on cbl_pkg, the channel interfaces in cbl_channels.sv and the core RTL.
`timescale 1ns / 100ps

module tb_calibration_bin_lookup_core;
  import cbl_pkg::*;

  typedef struct {
    action_t                 action;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [KEY_W-1:0] entry_value;
    logic signed [KEY_W-1:0] score;
  } bin_item_t;

  typedef struct {
    logic signed [KEY_W-1:0] calibrated;
    logic [IDX_W-1:0]        found_index;
    logic                    past_end;
  } bin_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    bin_item_t             item;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] data;
    bit                    typed;
    bin_result_t           want;
  } stim_row_t;

  localparam int NUM_PHASES   = 12;
  localparam int MIXED_ITEMS  = 48;
  localparam int IDLE_SETTLE  = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRESSURE_PH  = 6;

  logic clk;
  logic rst_n;

  cbl_in_if  in_bus();
  cbl_out_if out_bus();
  cbl_cfg_if cfg_bus();

  calibration_bin_lookup_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // predictor state
  logic signed [KEY_W-1:0] key_tbl [TABLE_DEPTH_DEF];
  logic signed [KEY_W-1:0] val_tbl [TABLE_DEPTH_DEF];
  bit                      written [TABLE_DEPTH_DEF];
  logic [CNT_W-1:0]        count_reg;
  mode_t                   mode_reg;

  bin_result_t pending_results[$];
  stim_row_t   stim_rows[$];
  int          err_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_arm;
  bit          hold_done;

  int unsigned phase_count [NUM_PHASES] = '{2, 3, 1, 7, 0, 256, 511, 64, 255, 129, 5, 300};
  mode_t phase_mode [NUM_PHASES] = '{MODE_UPPER, MODE_LOWER, MODE_LOWER, MODE_UPPER,
                                     MODE_LOWER, MODE_UPPER, MODE_LOWER, MODE_UPPER,
                                     MODE_LOWER, MODE_UPPER, MODE_UPPER, MODE_LOWER};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    err_count++;
  endtask

  function automatic int eff_count(input logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
    return int'(c);
  endfunction

  function automatic bin_result_t predict_lookup(input logic signed [KEY_W-1:0] s);
    bin_result_t r;
    int n, lo, len, half, mid;
    bit go_left;
    n  = eff_count(count_reg);
    lo = 0;
    len = (mode_reg == MODE_UPPER) ? n - 1 : n;
    while (len > 0) begin
      half = len >> 1;
      mid  = lo + half;
      go_left = (mode_reg == MODE_UPPER) ? (key_tbl[mid] > s) : !(key_tbl[mid] < s);
      if (go_left) begin
        len = half;
      end else begin
        lo  = mid + 1;
        len = len - half - 1;
      end
    end
    r.past_end = 1'b0;
    if (lo >= n) begin
      lo = n - 1;
      r.past_end = 1'b1;
    end
    r.calibrated  = val_tbl[lo];
    r.found_index = lo[IDX_W-1:0];
    return r;
  endfunction

  function automatic void add_write(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] k,
                                    input logic [KEY_W-1:0] v);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.typed = 1'b0;
    row.item  = '{ACT_WRITE, idx, k, v, $urandom};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_lookup(input logic [KEY_W-1:0] s);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.typed = 1'b0;
    row.item  = '{ACT_LOOKUP, IDX_W'($urandom_range(255)), $urandom, $urandom, s};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_check(input logic [KEY_W-1:0] s, input logic [KEY_W-1:0] cal,
                                    input logic [IDX_W-1:0] idx, input logic past);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.typed = 1'b1;
    row.item  = '{ACT_LOOKUP, IDX_W'($urandom_range(255)), $urandom, $urandom, s};
    row.want  = '{cal, idx, past};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_cfg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.sel  = sel;
    row.data = d;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  task automatic push_item(input bin_item_t it, input bit typed, input bin_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= it.action;
    in_bus.entry_index <= it.entry_index;
    in_bus.entry_key   <= it.entry_key;
    in_bus.entry_value <= it.entry_value;
    in_bus.score       <= it.score;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (it.action == ACT_WRITE) begin
      key_tbl[it.entry_index] = it.entry_key;
      val_tbl[it.entry_index] = it.entry_value;
      written[it.entry_index] = 1'b1;
    end else begin
      pending_results.insert(pending_results.size(), typed ? want : predict_lookup(it.score));
    end
  endtask

  task automatic cfg_write(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= sel;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (sel)
      REG_ENTRY_COUNT: count_reg = d;
      REG_SEARCH_MODE: mode_reg = mode_t'(d[0]);
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // quiesce before a register write: all lookups answered, trailing write retired
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic load_sorted_table(input int n);
    int keys[$];
    int r;
    int k;
    bin_item_t it;
    bin_result_t unused;
    unused = '{32'sd0, 8'd0, 1'b0};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (i > 0 && r < 15) k = keys[i-1];
      else if (r < 20) k = 32'h8000_0000;
      else if (r < 25) k = 32'h7FFF_FFFF;
      else k = $urandom;
      keys.insert(keys.size(), k);
    end
    keys.sort();
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      it.action      = ACT_WRITE;
      it.entry_index = i[IDX_W-1:0];
      it.entry_key   = keys[i];
      it.entry_value = (r < 5) ? 32'h8000_0000 : (r < 10) ? 32'h7FFF_FFFF : $urandom;
      it.score       = $urandom;
      push_item(it, 1'b0, unused);
    end
  endtask

  // receiver: random stalls, plus one long hold-off to back the core up
  initial begin
    int hold_left;
    hold_left = 0;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    bin_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result calibrated=%h found_index=%0d",
                                  out_bus.calibrated, out_bus.found_index));
      end else begin
        want = pending_results.pop_front();
        if (out_bus.calibrated !== want.calibrated)
          report_mismatch($sformatf("calibrated %h, want %h",
                                    out_bus.calibrated, want.calibrated));
        if (out_bus.found_index !== want.found_index)
          report_mismatch($sformatf("found_index %0d, want %0d",
                                    out_bus.found_index, want.found_index));
        if (out_bus.past_end !== want.past_end)
          report_mismatch($sformatf("past_end %b, want %b",
                                    out_bus.past_end, want.past_end));
      end
    end
  end

  initial begin
    bin_item_t   it;
    bin_result_t unused;
    int n, r, w, k;
    bit need_load;

    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm       = 1'b0;
    count_reg      = 1;
    mode_reg       = MODE_UPPER;
    unused         = '{32'sd0, 8'd0, 1'b0};
    foreach (written[i]) written[i] = 1'b0;

    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= ACT_WRITE;
    in_bus.entry_index <= '0;
    in_bus.entry_key   <= '0;
    in_bus.entry_value <= '0;
    in_bus.score       <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.idx        <= REG_ENTRY_COUNT;
    cfg_bus.data       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-entry clamps, lower-bound overrun, duplicate keys, count of zero
    add_write(8'd0, 32'h0001_0000, 32'h7FFF_FFFF);
    add_check(32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 1'b0);
    add_check(32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 1'b0);
    add_cfg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_LOWER));
    add_check(32'h0001_0000, 32'h7FFF_FFFF, 8'd0, 1'b0);
    add_check(32'h0001_0001, 32'h7FFF_FFFF, 8'd0, 1'b1);
    add_lookup(32'h8000_0000);
    add_write(8'd0, 32'h8000_0000, 32'h8000_0000);
    add_write(8'd1, 32'h0000_0000, 32'h0000_0001);
    add_write(8'd2, 32'h0000_0000, 32'h0000_0002);
    add_write(8'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_write(8'd255, 32'h7FFF_FFFF, 32'h0000_0000);
    add_cfg(REG_ENTRY_COUNT, 9'd4);
    add_check(32'h8000_0000, 32'h8000_0000, 8'd0, 1'b0);
    add_check(32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd3, 1'b0);
    add_lookup(32'h0000_0000);
    add_lookup(32'h0000_0001);
    add_cfg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_UPPER));
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h8000_0000);
    add_check(32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd3, 1'b0);
    add_cfg(REG_ENTRY_COUNT, 9'd0);
    add_check(32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 1'b0);
    add_cfg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_LOWER));
    add_check(32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 1'b1);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(stim_rows[i].sel, stim_rows[i].data);
      end else begin
        push_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      cfg_write(REG_ENTRY_COUNT, CFG_DATA_W'(phase_count[ph]));
      cfg_write(REG_SEARCH_MODE, CFG_DATA_W'(phase_mode[ph]));
      n = eff_count(count_reg);

      need_load = (n <= 64);
      for (int i = 0; i < n; i++) if (!written[i]) need_load = 1'b1;
      if (need_load) load_sorted_table(n);

      if (ph == PRESSURE_PH) hold_arm = 1'b1;

      for (int j = 0; j < MIXED_ITEMS; j++) begin
        r = $urandom_range(99);
        it.entry_index = IDX_W'($urandom_range(255));
        it.entry_key   = $urandom;
        it.entry_value = $urandom;
        it.score       = $urandom;
        if (r < 75) begin
          it.action = ACT_LOOKUP;
          r = $urandom_range(99);
          if (r < 80 && r >= 40)
            it.score = key_tbl[$urandom_range(n - 1)] + ($urandom_range(2) - 1);
          else if (r >= 80 && r < 90)
            it.score = 32'h8000_0000;
          else if (r >= 90)
            it.score = 32'h7FFF_FFFF;
        end else begin
          it.action = ACT_WRITE;
          w = $urandom_range(3);
          if (w < 3) begin
            k = $urandom_range(n - 1);
            it.entry_index = k[IDX_W-1:0];
            // value-only rewrite keeps the keys in order
            if (w < 2) it.entry_key = key_tbl[k];
          end
        end
        push_item(it, 1'b0, unused);
      end
    end

    in_bus.valid <= 1'b0;
    k = 0;
    while (pending_results.size() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d lookups never answered", pending_results.size()));
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ calibration_bin_lookup_core.f @@
+incdir+hw/rtl
hw/rtl/cbl_pkg.sv
hw/rtl/cbl_channels.sv
hw/rtl/calibration_bin_lookup_core.sv
hw/rtl/cbl_checker.sv
dv/tb_calibration_bin_lookup_core.sv
